@@ hw/rtl/tlf_pkg.sv @@
package tlf_pkg;

  localparam int unsigned CountW  = 13;
  localparam int unsigned RowW    = 12;
  localparam int unsigned HeightW = 8;
  localparam int unsigned TopW    = 13;
  localparam int unsigned NumW    = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 13;

  // Saturation points of the row pixel count and the row counter
  localparam logic [CountW-1:0] CountLimit = 13'd4096;
  localparam logic [RowW-1:0]   RowLimit   = 12'd4095;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLACK_THRESHOLD = 2'd0,
    CFG_LINE_BOX_HEIGHT = 2'd1,
    CFG_REGION_TOP      = 2'd2,
    CFG_REGION_ROWS     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [12:0]        black_threshold;
    logic [HeightW-1:0] line_box_height;
    logic [11:0]        region_top;
    logic [12:0]        region_rows;
  } cfg_t;

  // One closed text line on its way to the box stage
  typedef struct packed {
    logic [CountW-1:0] center;
    logic [NumW-1:0]   number;
  } line_evt_t;

endpackage

@@ hw/rtl/tlf_cfg.sv @@
module tlf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tlf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tlf_pkg::CfgW-1:0]     cfg_data_i,
  output tlf_pkg::cfg_t                cfg_o
);
  import tlf_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.black_threshold <= 13'd2;
      cfg_q.line_box_height <= 8'd25;
      cfg_q.region_top      <= 12'd0;
      cfg_q.region_rows     <= 13'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BLACK_THRESHOLD: cfg_q.black_threshold <= cfg_data_i;
        CFG_LINE_BOX_HEIGHT: cfg_q.line_box_height <= cfg_data_i[HeightW-1:0];
        CFG_REGION_TOP:      cfg_q.region_top      <= cfg_data_i[11:0];
        CFG_REGION_ROWS:     cfg_q.region_rows     <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/tlf_profile.sv @@
module tlf_profile (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 black_i,
  input  logic                 row_end_i,
  input  logic                 frame_end_i,
  input  logic [12:0]          black_threshold_i,
  output logic                 evt_valid_o,
  output tlf_pkg::line_evt_t   evt_o,
  input  logic                 evt_ready_i
);
  import tlf_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d, cnt_new;
  logic [RowW-1:0]   row_q, row_d, first_q, first_d, first_mid;
  logic              inside_q, inside_d;
  logic [NumW-1:0]   lines_q, lines_d;
  logic              evt_valid_q, evt_valid_d;
  line_evt_t         evt_q, evt_d;

  logic              eor, text_row, close_row, close_frame, emit;
  logic [CountW-1:0] end_row, span;

  always_comb begin
    cnt_new = cnt_q + CountW'(black_i && (cnt_q < CountLimit));
    eor       = row_end_i | frame_end_i;
    text_row  = cnt_new > black_threshold_i;
    first_mid = (text_row && !inside_q) ? row_q : first_q;
    // A non-text row closes an open line; frame end closes one still open
    close_row   = eor && !text_row && inside_q;
    close_frame = frame_end_i && text_row;
    emit        = close_row || close_frame;
    end_row = close_frame ? ({1'b0, row_q} + 13'd1) : {1'b0, row_q};
    span    = (end_row >= {1'b0, first_mid}) ? end_row - {1'b0, first_mid} : '0;

    cnt_d    = cnt_q;
    row_d    = row_q;
    inside_d = inside_q;
    first_d  = first_q;
    lines_d  = lines_q;
    if (accept_i) begin
      cnt_d = eor ? '0 : cnt_new;
      if (eor) begin
        first_d  = first_mid;
        inside_d = frame_end_i ? 1'b0 : text_row;
        if (frame_end_i) begin
          row_d = '0;
        end else if (row_q < RowLimit) begin
          row_d = row_q + 12'd1;
        end
      end
      if (frame_end_i) begin
        lines_d = '0;
      end else if (emit) begin
        lines_d = lines_q + 11'd1;
      end
    end

    evt_valid_d = evt_valid_q && !evt_ready_i;
    evt_d       = evt_q;
    if (accept_i && emit) begin
      evt_valid_d  = 1'b1;
      evt_d.center = {1'b0, first_mid} + (span >> 1);
      evt_d.number = lines_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      row_q       <= '0;
      inside_q    <= 1'b0;
      first_q     <= '0;
      lines_q     <= '0;
      evt_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      inside_q    <= inside_d;
      first_q     <= first_d;
      lines_q     <= lines_d;
      evt_valid_q <= evt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign evt_valid_o = evt_valid_q;
  assign evt_o       = evt_q;

`ifndef ASSERT_OFF
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountLimit) else $error("row count past its limit");
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && frame_end_i) |=> (row_q == '0 && !inside_q && lines_q == '0))
    else $error("frame end left line state behind");
  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_valid_q && !evt_ready_i) |=> (evt_valid_q && $stable(evt_q)))
    else $error("pending line lost");
`endif

endmodule

@@ hw/rtl/tlf_box.sv @@
module tlf_box (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         evt_valid_i,
  input  tlf_pkg::line_evt_t           evt_i,
  output logic                         evt_ready_o,
  input  tlf_pkg::cfg_t                cfg_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlf_pkg::TopW-1:0]     line_top_o,
  output logic [tlf_pkg::HeightW-1:0]  box_height_o,
  output logic [tlf_pkg::NumW-1:0]     line_number_o
);
  import tlf_pkg::*;

  logic               out_valid_q;
  logic [TopW-1:0]    top_q, top_d;
  logic [HeightW-1:0] height_q, height_d;
  logic [NumW-1:0]    num_q;
  logic [CountW-1:0]  half, offset;
  logic [CountW:0]    box_end;
  logic [CountW-1:0]  room;

  assign evt_ready_o = !out_valid_q || !out_stall_i;

  always_comb begin
    half    = {5'd0, cfg_i.line_box_height >> 1};
    offset  = (evt_i.center > half) ? evt_i.center - half : '0;
    box_end = {1'b0, offset} + {6'd0, cfg_i.line_box_height};
    room    = cfg_i.region_rows - offset;
    if (offset >= cfg_i.region_rows) begin
      height_d = '0;
    end else if (box_end > {1'b0, cfg_i.region_rows}) begin
      height_d = room[HeightW-1:0];
    end else begin
      height_d = cfg_i.line_box_height;
    end
    top_d = {1'b0, cfg_i.region_top} + offset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (evt_ready_o) begin
      out_valid_q <= evt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_ready_o && evt_valid_i) begin
      top_q    <= top_d;
      height_q <= height_d;
      num_q    <= evt_i.number;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_top_o    = top_q;
  assign box_height_o  = height_q;
  assign line_number_o = num_q;

`ifndef ASSERT_OFF
  a_height_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (height_q <= cfg_i.line_box_height))
    else $error("box taller than configured height");
`endif

endmodule

@@ hw/rtl/text_line_finder.sv @@
// Channel  | Direction | Handshake              | Payload
// input    | in        | in_valid_i / in_stall_o | black_i, row_end_i, frame_end_i
// output   | out       | out_valid_o / out_stall_i | line_top_o, box_height_o, line_number_o
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per cycle while in_stall_o is low. A closed line reaches the output
// through two registers: one for the line center, one for the box.
// Reset clears counters, line state and both valid flags; config takes its defaults.
// Output stall holds the box register; a pending center then stalls the input.
module text_line_finder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel requests
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         black_i,
  input  logic                         row_end_i,
  input  logic                         frame_end_i,
  // line box requests
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlf_pkg::TopW-1:0]     line_top_o,
  output logic [tlf_pkg::HeightW-1:0]  box_height_o,
  output logic [tlf_pkg::NumW-1:0]     line_number_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tlf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tlf_pkg::CfgW-1:0]     cfg_data_i
);
  import tlf_pkg::*;

  cfg_t      cfg;
  line_evt_t evt;
  logic      evt_valid, evt_ready, accept;

  // Hold the input only while a closed line waits behind a stalled output
  assign in_stall_o = evt_valid && !evt_ready;
  assign accept     = in_valid_i && !in_stall_o;

  tlf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Row projection: count black pixels, track open line, emit line centers
  tlf_profile u_profile (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .black_i           (black_i),
    .row_end_i         (row_end_i),
    .frame_end_i       (frame_end_i),
    .black_threshold_i (cfg.black_threshold),
    .evt_valid_o       (evt_valid),
    .evt_o             (evt),
    .evt_ready_i       (evt_ready)
  );

  // Turn a center into a clamped box and register it for the output
  tlf_box u_box (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_valid_i   (evt_valid),
    .evt_i         (evt),
    .evt_ready_o   (evt_ready),
    .cfg_i         (cfg),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_top_o    (line_top_o),
    .box_height_o  (box_height_o),
    .line_number_o (line_number_o)
  );

endmodule

@@ tb/testbench.sv @@
module testbench;
  import tlf_pkg::*;

  // Give up on a hung run well past the slowest legal schedule
  localparam int CycleLimit = 2_000_000;
  // Cycles of receiver hold-off for the long back-pressure stretch
  localparam int LongHold = 300;

  typedef struct packed {
    logic black;
    logic row_end;
    logic frame_end;
  } pixel_t;

  typedef struct packed {
    logic [TopW-1:0]    top;
    logic [HeightW-1:0] height;
    logic [NumW-1:0]    num;
  } line_box_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Start every input at a known value
  logic                in_valid_i  = 1'b0;
  logic                black_i     = 1'b0;
  logic                row_end_i   = 1'b0;
  logic                frame_end_i = 1'b0;
  logic                out_stall_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_data_i  = '0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic                cfg_ready_o;
  logic [TopW-1:0]     line_top_o;
  logic [HeightW-1:0]  box_height_o;
  logic [NumW-1:0]     line_number_o;

  text_line_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .black_i       (black_i),
    .row_end_i     (row_end_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_top_o    (line_top_o),
    .box_height_o  (box_height_o),
    .line_number_o (line_number_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Pixels waiting to be offered, and line boxes the block still owes us
  pixel_t    pixels_todo[$];
  line_box_t boxes_due[$];

  int errors = 0;
  int pixels_queued = 0;
  int cycles = 0;
  bit quiet = 1'b0;          // set for the tail of the run: no idling on either side
  int long_hold_req = 0;     // bumped by the sequence to ask for one long hold-off
  int long_hold_done = 0;

  // Shadow of the register file, kept in step with every accepted write
  int unsigned thr_cfg  = 2;
  int unsigned boxh_cfg = 25;
  int unsigned top_cfg  = 0;
  int unsigned rows_cfg = 1;

  // Line finder state as the block should hold it
  int unsigned px_count   = 0;
  int unsigned row_now    = 0;
  bit          line_open  = 1'b0;
  int unsigned open_row   = 0;
  int unsigned lines_out  = 0;

  // Driver and monitor bookkeeping
  pixel_t next_px;
  int     send_gap = 0;
  int     stall_left = 0;
  int     hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Build the box for a closed line centered on row 'center'
  function automatic void emit_box(int unsigned center);
    int unsigned half;
    int unsigned off;
    int unsigned h;
    line_box_t   box;
    half = boxh_cfg / 2;
    off  = (center > half) ? center - half : 0;
    h    = boxh_cfg;
    // Cut the box at the region's bottom edge; give it zero height when it starts at or past it
    if (off >= rows_cfg) begin
      h = 0;
    end else if (off + h > rows_cfg) begin
      h = rows_cfg - off;
    end
    box.top    = TopW'(top_cfg + off);
    box.height = HeightW'(h);
    box.num    = NumW'(lines_out);
    boxes_due.push_back(box);
    lines_out = (lines_out + 1) % (1 << NumW);
  endfunction

  // Advance the expected state by one accepted pixel
  function automatic void track_pixel(logic b, logic re, logic fe);
    int unsigned span;
    if (b && px_count < CountLimit) px_count++;
    // Frame end also closes the current row
    if (re || fe) begin
      if (px_count > thr_cfg) begin
        if (!line_open) begin
          line_open  = 1'b1;
          open_row   = row_now;
        end
      end else if (line_open) begin
        span = (row_now >= open_row) ? row_now - open_row : 0;
        line_open = 1'b0;
        emit_box(open_row + span / 2);
      end
      // Flush a line still open at frame end, counting the final row in its span
      if (fe && line_open) begin
        span = (row_now + 1 >= open_row) ? row_now + 1 - open_row : 0;
        line_open = 1'b0;
        emit_box(open_row + span / 2);
      end
      px_count = 0;
      if (fe) begin
        row_now   = 0;
        line_open = 1'b0;
        lines_out = 0;
      end else if (row_now < RowLimit) begin
        row_now++;
      end
    end
  endfunction

  // Pixel driver: hold a stalled request, otherwise idle in bursts or advance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) track_pixel(black_i, row_end_i, frame_end_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!quiet && pixels_todo.size() != 0 && $urandom_range(0, 11) == 0) begin
          // Idle now, then for the further gap drawn into send_gap
          send_gap = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else if (pixels_todo.size() != 0) begin
          next_px = pixels_todo.pop_front();
          in_valid_i  <= 1'b1;
          black_i     <= next_px.black;
          row_end_i   <= next_px.row_end;
          frame_end_i <= next_px.frame_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Box monitor: check each accepted box, and drive back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (boxes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected box top=%0d height=%0d line=%0d", $time,
                   line_top_o, box_height_o, line_number_o);
        end else begin
          if (line_top_o !== boxes_due[0].top) begin
            errors++;
            $display("%0t: line_top expected %0d actual %0d", $time,
                     boxes_due[0].top, line_top_o);
          end
          if (box_height_o !== boxes_due[0].height) begin
            errors++;
            $display("%0t: box_height expected %0d actual %0d", $time,
                     boxes_due[0].height, box_height_o);
          end
          if (line_number_o !== boxes_due[0].num) begin
            errors++;
            $display("%0t: line_number expected %0d actual %0d", $time,
                     boxes_due[0].num, line_number_o);
          end
          void'(boxes_due.pop_front());
        end
      end
      // Pick up a long hold-off request and count it down here
      if (long_hold_req != long_hold_done) begin
        long_hold_done++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic push_px(input bit b, input bit re, input bit fe);
    pixel_t p;
    p.black     = b;
    p.row_end   = re;
    p.frame_end = fe;
    pixels_todo.push_back(p);
    pixels_queued++;
  endtask

  // Wait until every pixel is in and every box is out, then let the pipe empty
  task automatic settle();
    while (pixels_todo.size() != 0 || in_valid_i || boxes_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BLACK_THRESHOLD: thr_cfg  = val % (1 << 13);
      CFG_LINE_BOX_HEIGHT: boxh_cfg = val % (1 << HeightW);
      CFG_REGION_TOP:      top_cfg  = val % (1 << 12);
      CFG_REGION_ROWS:     rows_cfg = val % (1 << 13);
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned thr, input int unsigned boxh,
                          input int unsigned top, input int unsigned rows);
    write_reg(CFG_BLACK_THRESHOLD, thr);
    write_reg(CFG_LINE_BOX_HEIGHT, boxh);
    write_reg(CFG_REGION_TOP, top);
    write_reg(CFG_REGION_ROWS, rows);
  endtask

  // Queue one frame of rows that drift between text and blank; noisy frames
  // ignore the drift, and some frames end without a row end on the last pixel
  task automatic queue_frame(input int n_rows, input int max_w);
    bit text_now;
    bit noisy;
    bit last_px;
    bit last_row;
    int w;
    int dens;
    text_now = $urandom_range(0, 1);
    noisy    = ($urandom_range(0, 9) == 0);
    for (int r = 0; r < n_rows; r++) begin
      if ($urandom_range(0, 3) == 0) text_now = !text_now;
      w = $urandom_range(1, max_w);
      if (noisy) dens = $urandom_range(0, 100);
      else dens = text_now ? $urandom_range(60, 100) : $urandom_range(0, 30);
      last_row = (r == n_rows - 1);
      for (int p = 0; p < w; p++) begin
        last_px = (p == w - 1);
        push_px($urandom_range(1, 100) <= dens,
                last_px && !(last_row && $urandom_range(0, 3) == 0),
                last_px && last_row);
      end
    end
  endtask

  initial begin
    int thr;
    int boxh;
    int top;
    int rows;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: three-pixel text row, blank row, then a text row cut by frame end
    push_px(1, 0, 0); push_px(1, 0, 0); push_px(1, 1, 0);
    push_px(0, 1, 0);
    push_px(1, 0, 0); push_px(1, 0, 0); push_px(1, 0, 1);
    settle();

    // Wide box at the top of the coordinate range, lowest threshold
    set_regs(0, 255, 4095, 4096);
    push_px(1, 1, 0); push_px(1, 1, 0); push_px(0, 1, 0);
    push_px(0, 0, 0); push_px(1, 0, 0); push_px(0, 0, 1);
    push_px(1, 1, 1);
    push_px(0, 0, 1);
    settle();

    // Threshold at the saturation point: a saturated row count still does not reach it
    set_regs(4096, 1, 0, 2);
    for (int i = 0; i < 4100; i++) push_px(1, i == 4099, 0);
    push_px(0, 1, 1);
    settle();

    // One below the saturated count: the same row now opens a line
    write_reg(CFG_BLACK_THRESHOLD, 4095);
    for (int i = 0; i < 4100; i++) push_px(1, i == 4099, 0);
    push_px(0, 1, 1);
    settle();

    // Zero box height and zero region rows fall into the bottom clamp
    set_regs(0, 0, 100, 0);
    push_px(1, 1, 0); push_px(0, 1, 0); push_px(1, 1, 0); push_px(1, 1, 1);
    settle();

    // One long frame of alternating text and blank rows: the row counter
    // saturates and the line number wraps. Hold off the receiver meanwhile
    // so the block backs up and stalls its pixel input.
    set_regs(0, 7, 4000, 3);
    long_hold_req++;
    for (int i = 0; i < 2100; i++) begin
      push_px(1, 1, 0);
      push_px(0, 1, 0);
    end
    push_px(1, 1, 1);
    settle();

    // Random phases, each under fresh settings with the extremes mixed in
    pixels_queued = 0;
    while (pixels_queued < 1000) begin
      case ($urandom_range(0, 9))
        0: thr = 0;
        1: thr = 4096;
        default: thr = $urandom_range(0, 8);
      endcase
      case ($urandom_range(0, 9))
        0: boxh = 1;
        1: boxh = 255;
        default: boxh = $urandom_range(1, 60);
      endcase
      case ($urandom_range(0, 9))
        0: top = 0;
        1: top = 4095;
        default: top = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 9))
        0: rows = 1;
        1: rows = 4096;
        default: rows = $urandom_range(1, 40);
      endcase
      set_regs(thr, boxh, top, rows);
      // Drop idling for the tail of the run
      if (pixels_queued > 800) quiet = 1'b1;
      repeat ($urandom_range(1, 4)) queue_frame($urandom_range(1, 30), $urandom_range(1, 12));
      settle();
    end

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
